// ===== hw/rtl/crcp_pkg.sv =====
package crcp_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int RADIUS_BITS    = 12;
  localparam int SIZE_BITS      = 15;
  localparam int IDENT_BITS     = 16;
  localparam int PUSH_BITS      = 15;
  localparam int MAG_BITS       = 13;
  localparam int SQ_BITS        = 2 * MAG_BITS;
  localparam int RSQ_BITS       = 2 * RADIUS_BITS;
  localparam int DIST_CAP       = 4096;

  // contact kind codes
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_X    = 2'd1,
    KIND_Y    = 2'd2,
    KIND_BOTH = 2'd3
  } kind_t;

  // per-stage advance enables of the shared pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage

// ===== hw/rtl/crcp_axis.sv =====
module crcp_axis
  import crcp_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                          clk,
  input  stage_en_t                     en,
  input  logic signed [COORD_BITS-1:0]  c,
  input  logic signed [COORD_BITS-1:0]  lo,
  input  logic        [SIZE_BITS-1:0]   len,
  input  logic        [RADIUS_BITS-1:0] radius,
  output logic                          band,
  output logic        [SQ_BITS-1:0]     sq,
  output logic        [PUSH_BITS-1:0]   push
);

  localparam int EXT = ((COORD_BITS > SIZE_BITS + 1) ? COORD_BITS : SIZE_BITS + 1) + 2;

  // stage 1: offset from near edge
  logic signed [EXT-1:0]       d_lo;
  logic        [SIZE_BITS-1:0] len_s1;

  // stage 2: clamp result
  logic signed [EXT-1:0]       d_end;
  logic                        gt;
  logic                        band_next;
  logic signed [EXT-1:0]       dx_next;
  logic signed [EXT-1:0]       dx;
  logic                        band_s2;
  logic                        sign_s2;

  // stage 3: capped magnitude
  logic        [EXT-1:0]       mag;
  logic        [MAG_BITS-1:0]  m_next;
  logic        [MAG_BITS-1:0]  m;
  logic        [PUSH_BITS-1:0] dx_s3;
  logic                        band_s3;
  logic                        sign_s3;

  // stage 4: square and pushback
  logic        [PUSH_BITS-1:0] rs;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      d_lo   <= EXT'(c) - EXT'(lo);
      len_s1 <= len;
    end
  end

  always_comb begin
    d_end     = d_lo - $signed({{(EXT - SIZE_BITS){1'b0}}, len_s1});
    gt        = d_lo > $signed(EXT'(0));
    band_next = gt && (d_end < $signed(EXT'(0)));
    if (!gt) begin
      dx_next = d_lo;
    end else if (band_next) begin
      dx_next = '0;
    end else begin
      dx_next = d_end;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      dx      <= dx_next;
      band_s2 <= band_next;
      sign_s2 <= gt;
    end
  end

  always_comb begin
    mag = dx[EXT-1] ? EXT'(-dx) : EXT'(dx);
    if (mag > EXT'(DIST_CAP)) begin
      m_next = MAG_BITS'(DIST_CAP);
    end else begin
      m_next = mag[MAG_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      m       <= m_next;
      dx_s3   <= dx[PUSH_BITS-1:0];
      band_s3 <= band_s2;
      sign_s3 <= sign_s2;
    end
  end

  // only the low bits of the pushback survive, so modular 15-bit math is enough
  assign rs = sign_s3 ? PUSH_BITS'(radius) : PUSH_BITS'(-PUSH_BITS'(radius));

  always_ff @(posedge clk) begin
    if (en.s4) begin
      sq   <= m * m;
      push <= rs - dx_s3;
      band <= band_s3;
    end
  end

endmodule

// ===== hw/rtl/circle_rect_contact_pushback_unit.sv =====
// circle against axis-aligned rectangle contact test. each input transaction
// carries a circle centre and a rectangle (left, top, width, height, id); the
// radius comes from the single config register, written over the cfg channel
// (always ready); the user must write it only while the unit is idle, which
// is not enforced. each axis is clamped on its own, the capped squared
// distances are summed and compared against radius squared, and a contact
// is reported only when that test passes and at least one axis lies strictly
// inside its band; a corner-only hit still raises hit_taken and hit_ident.
// one result per input transaction, in order. the unit takes one transaction
// per clock through five register stages (edge offset, clamp, magnitude cap,
// square/pushback, compare/output); an output stall holds the whole pipeline
// and shows up on in_stall in the same cycle once every stage is full.
module circle_rect_contact_pushback_unit
  import crcp_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,

  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic        [RADIUS_BITS-1:0] cfg_data,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_BITS-1:0]  centre_x,
  input  logic signed [COORD_BITS-1:0]  centre_y,
  input  logic signed [COORD_BITS-1:0]  box_left,
  input  logic signed [COORD_BITS-1:0]  box_top,
  input  logic        [SIZE_BITS-1:0]   box_width,
  input  logic        [SIZE_BITS-1:0]   box_height,
  input  logic        [IDENT_BITS-1:0]  box_ident,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          touching,
  output logic        [1:0]             contact_kind,
  output logic signed [PUSH_BITS-1:0]   push_x,
  output logic signed [PUSH_BITS-1:0]   push_y,
  output logic                          hit_taken,
  output logic        [IDENT_BITS-1:0]  hit_ident
);

  // config register and its square, refreshed every cycle
  logic [RADIUS_BITS-1:0] radius;
  logic [RSQ_BITS-1:0]    rsq;

  // pipeline valid bits and advance enables
  logic      v1, v2, v3, v4, v5;
  logic      en5;
  stage_en_t en;

  // id travels alongside the axis pipelines
  logic [IDENT_BITS-1:0] id1, id2, id3, id4;

  // axis results at stage 4
  logic                 band_x, band_y;
  logic [SQ_BITS-1:0]   sq_x, sq_y;
  logic [PUSH_BITS-1:0] px, py;

  // stage 5 decision
  logic [SQ_BITS:0]     dist_sq;
  logic                 hit;
  kind_t                kind;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= '0;
    end else if (cfg_valid && cfg_ready) begin
      radius <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    rsq <= radius * radius;
  end

  // a stage moves when it is empty or its successor moves
  assign en5   = !v5 || !out_stall;
  assign en.s4 = !v4 || en5;
  assign en.s3 = !v3 || en.s4;
  assign en.s2 = !v2 || en.s3;
  assign en.s1 = !v1 || en.s2;

  assign in_stall  = !en.s1;
  assign out_valid = v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en.s1) begin
        v1 <= in_valid;
      end
      if (en.s2) begin
        v2 <= v1;
      end
      if (en.s3) begin
        v3 <= v2;
      end
      if (en.s4) begin
        v4 <= v3;
      end
      if (en5) begin
        v5 <= v4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      id1 <= box_ident;
    end
    if (en.s2) begin
      id2 <= id1;
    end
    if (en.s3) begin
      id3 <= id2;
    end
    if (en.s4) begin
      id4 <= id3;
    end
  end

  crcp_axis #(
    .COORD_BITS(COORD_BITS)
  ) u_axis_x (
    .clk    (clk),
    .en     (en),
    .c      (centre_x),
    .lo     (box_left),
    .len    (box_width),
    .radius (radius),
    .band   (band_x),
    .sq     (sq_x),
    .push   (px)
  );

  crcp_axis #(
    .COORD_BITS(COORD_BITS)
  ) u_axis_y (
    .clk    (clk),
    .en     (en),
    .c      (centre_y),
    .lo     (box_top),
    .len    (box_height),
    .radius (radius),
    .band   (band_y),
    .sq     (sq_y),
    .push   (py)
  );

  // squared distance strictly below radius squared
  assign dist_sq = (SQ_BITS + 1)'(sq_x) + (SQ_BITS + 1)'(sq_y);
  assign hit     = dist_sq < (SQ_BITS + 1)'(rsq);

  always_comb begin
    if (!hit) begin
      kind = KIND_NONE;
    end else begin
      unique case ({band_y, band_x})
        2'b00:   kind = KIND_NONE;
        2'b01:   kind = KIND_X;
        2'b10:   kind = KIND_Y;
        default: kind = KIND_BOTH;
      endcase
    end
  end

  // x push goes out when the y band holds, y push when the x band holds
  always_ff @(posedge clk) begin
    if (en5) begin
      touching     <= kind != KIND_NONE;
      contact_kind <= kind;
      push_x       <= (kind == KIND_Y || kind == KIND_BOTH) ? px : '0;
      push_y       <= (kind == KIND_X || kind == KIND_BOTH) ? py : '0;
      hit_taken    <= hit;
      hit_ident    <= hit ? id4 : '0;
    end
  end

endmodule
